// File: hdl/cte_pkg.sv
// shared types, constants and range functions for the time-setting editor
package cte_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KEY_MODE = 2'd0,
    KEY_NEXT = 2'd1,
    KEY_INC  = 2'd2,
    KEY_DEC  = 2'd3
  } key_t;

  localparam int NUM_FIELDS = 6;

  localparam logic [2:0] F_YEAR   = 3'd0;
  localparam logic [2:0] F_MONTH  = 3'd1;
  localparam logic [2:0] F_DATE   = 3'd2;
  localparam logic [2:0] F_HOUR   = 3'd3;
  localparam logic [2:0] F_MINUTE = 3'd4;
  localparam logic [2:0] F_SECOND = 3'd5;

  localparam logic [15:0] BLINK_TICKS_RESET = 16'd1000;

  // field limits, signed so that a decrement below zero compares right
  localparam logic signed [8:0] YEAR_MIN   = 9'sd0;
  localparam logic signed [8:0] YEAR_MAX   = 9'sd99;
  localparam logic signed [8:0] MONTH_MIN  = 9'sd1;
  localparam logic signed [8:0] MONTH_MAX  = 9'sd12;
  localparam logic signed [8:0] DATE_MIN   = 9'sd1;
  localparam logic signed [8:0] HOUR_MIN   = 9'sd0;
  localparam logic signed [8:0] HOUR_MAX   = 9'sd23;
  localparam logic signed [8:0] MINSEC_MIN = 9'sd0;
  localparam logic signed [8:0] MINSEC_MAX = 9'sd59;

  typedef struct packed {
    cmd_t       cmd;
    key_t       key;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } item_t;

  typedef struct packed {
    logic [6:0] year;
    logic [6:0] month;
    logic [6:0] date;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [2:0] selected;
    logic       blank_selected;
    logic       editing;
    logic       commit;
  } res_t;

  function automatic logic [6:0] wrap_range(input logic signed [8:0] v,
                                            input logic signed [8:0] lo,
                                            input logic signed [8:0] hi);
    logic signed [8:0] r;
    if (v < lo) r = hi;
    else if (v > hi) r = lo;
    else r = v;
    return r[6:0];
  endfunction

  // last date of the month, leap year when the year is a multiple of four
  function automatic logic signed [8:0] date_max(input logic [6:0] month,
                                                 input logic [6:0] year);
    logic signed [8:0] d;
    if (month == 7'd2) d = (year[1:0] == 2'b00) ? 9'sd29 : 9'sd28;
    else if (month inside {7'd4, 7'd6, 7'd9, 7'd11}) d = 9'sd30;
    else d = 9'sd31;
    return d;
  endfunction

endpackage

// File: hdl/cte_in_stage.sv
// input register stage holding one accepted word
module cte_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cte_pkg::item_t item_in,
  output cte_pkg::item_t item,
  output logic           valid,
  input  logic           take
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

// File: hdl/cte_core.sv
// editor state registers and the one-pass update for a word
module cte_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           advance,
  input  cte_pkg::item_t item,
  output cte_pkg::res_t  result
);

  logic [6:0]  fields [cte_pkg::NUM_FIELDS];
  logic        edit_active;
  logic [2:0]  field_select;
  logic        blink_phase;
  logic [15:0] tick_count;
  logic [15:0] blink_ticks;

  logic [6:0]  fields_next [cte_pkg::NUM_FIELDS];
  logic        edit_active_next;
  logic [2:0]  field_select_next;
  logic        blink_phase_next;
  logic [15:0] tick_count_next;
  logic        commit_next;

  always_comb begin
    logic signed [8:0] vals [cte_pkg::NUM_FIELDS];
    logic signed [8:0] base;
    logic [2:0]        sel;
    logic [15:0]       tick_inc;
    logic [6:0]        year_w;
    logic [6:0]        month_w;

    for (int i = 0; i < cte_pkg::NUM_FIELDS; i++) begin
      fields_next[i] = fields[i];
      vals[i]        = $signed({2'b00, fields[i]});
    end
    edit_active_next  = edit_active;
    field_select_next = field_select;
    blink_phase_next  = blink_phase;
    tick_count_next   = tick_count;
    commit_next       = 1'b0;

    sel  = (field_select > cte_pkg::F_SECOND) ? cte_pkg::F_YEAR : field_select;
    base = $signed({2'b00, fields[sel]});
    vals[sel] = (item.key == cte_pkg::KEY_INC) ? base + 9'sd1 : base - 9'sd1;

    // year and month settle first, the date limit follows them
    year_w  = cte_pkg::wrap_range(vals[cte_pkg::F_YEAR], cte_pkg::YEAR_MIN,
                                  cte_pkg::YEAR_MAX);
    month_w = cte_pkg::wrap_range(vals[cte_pkg::F_MONTH], cte_pkg::MONTH_MIN,
                                  cte_pkg::MONTH_MAX);
    tick_inc = tick_count + 16'd1;

    case (item.cmd)
      cte_pkg::CMD_TICK: begin
        if (tick_inc >= blink_ticks) begin
          tick_count_next = '0;
          if (edit_active) blink_phase_next = !blink_phase;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      cte_pkg::CMD_KEY: begin
        case (item.key)
          cte_pkg::KEY_MODE: begin
            if (edit_active) begin
              edit_active_next = 1'b0;
              commit_next      = 1'b1;
              blink_phase_next = 1'b0;
            end else begin
              edit_active_next = 1'b1;
            end
          end
          cte_pkg::KEY_NEXT: begin
            if (edit_active) begin
              field_select_next = (sel == cte_pkg::F_SECOND) ? cte_pkg::F_YEAR
                                                             : sel + 3'd1;
            end
          end
          cte_pkg::KEY_INC, cte_pkg::KEY_DEC: begin
            if (edit_active) begin
              fields_next[cte_pkg::F_YEAR]   = year_w;
              fields_next[cte_pkg::F_MONTH]  = month_w;
              fields_next[cte_pkg::F_DATE]   = cte_pkg::wrap_range(
                vals[cte_pkg::F_DATE], cte_pkg::DATE_MIN,
                cte_pkg::date_max(month_w, year_w));
              fields_next[cte_pkg::F_HOUR]   = cte_pkg::wrap_range(
                vals[cte_pkg::F_HOUR], cte_pkg::HOUR_MIN, cte_pkg::HOUR_MAX);
              fields_next[cte_pkg::F_MINUTE] = cte_pkg::wrap_range(
                vals[cte_pkg::F_MINUTE], cte_pkg::MINSEC_MIN, cte_pkg::MINSEC_MAX);
              fields_next[cte_pkg::F_SECOND] = cte_pkg::wrap_range(
                vals[cte_pkg::F_SECOND], cte_pkg::MINSEC_MIN, cte_pkg::MINSEC_MAX);
            end
          end
          default: begin
          end
        endcase
      end
      cte_pkg::CMD_SAMPLE: begin
        if (!edit_active) begin
          fields_next[cte_pkg::F_YEAR]   = item.year;
          fields_next[cte_pkg::F_MONTH]  = {3'b000, item.month};
          fields_next[cte_pkg::F_DATE]   = {2'b00, item.date};
          fields_next[cte_pkg::F_HOUR]   = {2'b00, item.hour};
          fields_next[cte_pkg::F_MINUTE] = {1'b0, item.minute};
          fields_next[cte_pkg::F_SECOND] = {1'b0, item.second};
          blink_phase_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.year           = fields_next[cte_pkg::F_YEAR];
    result.month          = fields_next[cte_pkg::F_MONTH];
    result.date           = fields_next[cte_pkg::F_DATE];
    result.hour           = fields_next[cte_pkg::F_HOUR];
    result.minute         = fields_next[cte_pkg::F_MINUTE];
    result.second         = fields_next[cte_pkg::F_SECOND];
    result.selected       = field_select_next;
    result.blank_selected = blink_phase_next;
    result.editing        = edit_active_next;
    result.commit         = commit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cte_pkg::NUM_FIELDS; i++) fields[i] <= '0;
      edit_active  <= 1'b0;
      field_select <= cte_pkg::F_YEAR;
      blink_phase  <= 1'b0;
      tick_count   <= '0;
    end else if (advance) begin
      for (int i = 0; i < cte_pkg::NUM_FIELDS; i++) fields[i] <= fields_next[i];
      edit_active  <= edit_active_next;
      field_select <= field_select_next;
      blink_phase  <= blink_phase_next;
      tick_count   <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ticks <= cte_pkg::BLINK_TICKS_RESET;
    end else if (cfg_we) begin
      blink_ticks <= cfg_wdata;
    end
  end

endmodule

// File: hdl/clock_time_set_editor.sv
// top level of the calendar clock time-setting editor
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   input    | in_valid / in_ready     | cmd, key, in_year .. in_second
//   output   | out_valid / out_ready   | out_year .. out_second, selected,
//            |                         | blank_selected, editing, commit
//   config   | cfg_we                  | cfg_wdata (blink_ticks, 16 bit)
//
// one word per cycle sustained while out_ready stays high; an accepted word goes
// through the input register, then the state update and result register in one pass
// synchronous reset: count mode, year selected, all fields and counters zero,
// blink period back to 1000 ticks
// an output stall holds the result register; the input register takes one more word
// only if it is empty, then in_ready drops until the result is taken
module clock_time_set_editor (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [1:0]  key,
  input  logic [6:0]  in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_date,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_year,
  output logic [6:0]  out_month,
  output logic [6:0]  out_date,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  output logic [2:0]  selected,
  output logic        blank_selected,
  output logic        editing,
  output logic        commit,
  // blink period register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cte_pkg::item_t item_in;
  cte_pkg::item_t item;
  logic           s1_valid;
  logic           s1_take;
  cte_pkg::res_t  result;
  cte_pkg::res_t  res_reg;

  // gather the input word
  always_comb begin
    item_in.cmd    = cte_pkg::cmd_t'(cmd);
    item_in.key    = cte_pkg::key_t'(key);
    item_in.year   = in_year;
    item_in.month  = in_month;
    item_in.date   = in_date;
    item_in.hour   = in_hour;
    item_in.minute = in_minute;
    item_in.second = in_second;
  end

  // the held word moves on whenever the result register is free or emptying
  assign s1_take = s1_valid && (!out_valid || out_ready);

  cte_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .item     (item),
    .valid    (s1_valid),
    .take     (s1_take)
  );

  // state update happens on the same edge the result is captured
  cte_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (s1_take),
    .item      (item),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res_reg <= result;
    end
  end

  assign out_year       = res_reg.year;
  assign out_month      = res_reg.month;
  assign out_date       = res_reg.date;
  assign out_hour       = res_reg.hour;
  assign out_minute     = res_reg.minute;
  assign out_second     = res_reg.second;
  assign selected       = res_reg.selected;
  assign blank_selected = res_reg.blank_selected;
  assign editing        = res_reg.editing;
  assign commit         = res_reg.commit;

endmodule

// File: hdl/cte_checker.sv
// port-level checks for the time-setting editor, bound to the top level
module cte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  cmd,
  input logic [1:0]  key,
  input logic [6:0]  in_year,
  input logic [3:0]  in_month,
  input logic [4:0]  in_date,
  input logic [4:0]  in_hour,
  input logic [5:0]  in_minute,
  input logic [5:0]  in_second,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_year,
  input logic [6:0]  out_month,
  input logic [6:0]  out_date,
  input logic [6:0]  out_hour,
  input logic [6:0]  out_minute,
  input logic [6:0]  out_second,
  input logic [2:0]  selected,
  input logic        blank_selected,
  input logic        editing,
  input logic        commit,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata
);

  // a commit word always reports count mode
  a_commit_leaves_edit: assert property (@(posedge clk) disable iff (rst)
    out_valid && commit |-> !editing)
    else $error("commit shown while still editing");

  // blink phase only runs in edit mode
  a_no_blank_in_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !editing |-> !blank_selected)
    else $error("blank phase set in count mode");

  a_selected_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> selected <= 3'd5)
    else $error("selected field out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_date) && $stable(out_hour) && $stable(out_minute)
      && $stable(out_second) && $stable(selected) && $stable(blank_selected)
      && $stable(editing) && $stable(commit))
    else $error("stalled result changed");

endmodule

bind clock_time_set_editor cte_checker u_cte_checker (.*);

// File: sim/tb_clock_time_set_editor.sv
// self-checking testbench for the clock time-setting editor with a predicting scoreboard
class time_edit_scoreboard;
  logic [6:0]    fld [cte_pkg::NUM_FIELDS];
  bit            edit;
  logic [2:0]    sel;
  bit            blink;
  logic [15:0]   ticks;
  logic [15:0]   period;
  cte_pkg::res_t expq [$];
  int            mismatches;
  int            checked;
  int            commits;

  function new();
    for (int i = 0; i < cte_pkg::NUM_FIELDS; i++) fld[i] = 7'd0;
    edit = 0;
    sel = cte_pkg::F_YEAR;
    blink = 0;
    ticks = 16'd0;
    period = cte_pkg::BLINK_TICKS_RESET;
  endfunction

  function void set_period(logic [15:0] v);
    period = v;
  endfunction

  function bit editing_now();
    return edit;
  endfunction

  function int pending();
    return expq.size();
  endfunction

  function logic [6:0] fit_range(int v, int lo, int hi);
    if (v < lo) return 7'(hi);
    if (v > hi) return 7'(lo);
    return 7'(v);
  endfunction

  // step the selected field, then pull every field back into its range
  function void adjust(int s, int delta);
    int v [cte_pkg::NUM_FIELDS];
    int dmax;
    logic [6:0] m;
    logic [6:0] y;
    for (int i = 0; i < cte_pkg::NUM_FIELDS; i++) v[i] = fld[i];
    v[s] = v[s] + delta;
    fld[cte_pkg::F_YEAR] = fit_range(v[cte_pkg::F_YEAR], 0, 99);
    fld[cte_pkg::F_MONTH] = fit_range(v[cte_pkg::F_MONTH], 1, 12);
    m = fld[cte_pkg::F_MONTH];
    y = fld[cte_pkg::F_YEAR];
    if (m == 7'd2) dmax = (y[1:0] == 2'b00) ? 29 : 28;
    else if (m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) dmax = 30;
    else dmax = 31;
    fld[cte_pkg::F_DATE] = fit_range(v[cte_pkg::F_DATE], 1, dmax);
    fld[cte_pkg::F_HOUR] = fit_range(v[cte_pkg::F_HOUR], 0, 23);
    fld[cte_pkg::F_MINUTE] = fit_range(v[cte_pkg::F_MINUTE], 0, 59);
    fld[cte_pkg::F_SECOND] = fit_range(v[cte_pkg::F_SECOND], 0, 59);
  endfunction

  function void note(cte_pkg::item_t w);
    cte_pkg::res_t r;
    bit   cm;
    int   s;
    cm = 0;
    case (w.cmd)
      cte_pkg::CMD_TICK: begin
        ticks = ticks + 16'd1;
        if (ticks >= period) begin
          ticks = 16'd0;
          if (edit) blink = !blink;
        end
      end
      cte_pkg::CMD_KEY: begin
        if (w.key == cte_pkg::KEY_MODE) begin
          if (edit) begin
            edit = 0;
            cm = 1;
            blink = 0;
          end else begin
            edit = 1;
          end
        end else if (edit) begin
          s = (sel >= cte_pkg::NUM_FIELDS) ? 0 : int'(sel);
          case (w.key)
            cte_pkg::KEY_NEXT: sel = 3'((s + 1 >= cte_pkg::NUM_FIELDS) ? 0 : s + 1);
            cte_pkg::KEY_INC:  adjust(s, 1);
            default:           adjust(s, -1);
          endcase
        end
      end
      cte_pkg::CMD_SAMPLE: begin
        if (!edit) begin
          fld[cte_pkg::F_YEAR] = w.year;
          fld[cte_pkg::F_MONTH] = {3'b000, w.month};
          fld[cte_pkg::F_DATE] = {2'b00, w.date};
          fld[cte_pkg::F_HOUR] = {2'b00, w.hour};
          fld[cte_pkg::F_MINUTE] = {1'b0, w.minute};
          fld[cte_pkg::F_SECOND] = {1'b0, w.second};
          blink = 0;
        end
      end
      default: ;
    endcase
    r.year = fld[cte_pkg::F_YEAR];
    r.month = fld[cte_pkg::F_MONTH];
    r.date = fld[cte_pkg::F_DATE];
    r.hour = fld[cte_pkg::F_HOUR];
    r.minute = fld[cte_pkg::F_MINUTE];
    r.second = fld[cte_pkg::F_SECOND];
    r.selected = sel;
    r.blank_selected = blink;
    r.editing = edit;
    r.commit = cm;
    expq.push_back(r);
  endfunction

  function void check(cte_pkg::res_t got);
    cte_pkg::res_t e;
    logic [6:0] ev [10];
    logic [6:0] gv [10];
    string nm [10] = '{"out_year", "out_month", "out_date", "out_hour", "out_minute",
                       "out_second", "selected", "blank_selected", "editing", "commit"};
    if (expq.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("error: result word with nothing pending: %p", got);
      return;
    end
    e = expq.pop_front();
    checked++;
    if (got.commit === 1'b1) commits++;
    if (got !== e) begin
      mismatches++;
      if (mismatches <= 10) begin
        ev = '{e.year, e.month, e.date, e.hour, e.minute, e.second,
               7'(e.selected), 7'(e.blank_selected), 7'(e.editing), 7'(e.commit)};
        gv = '{got.year, got.month, got.date, got.hour, got.minute, got.second,
               7'(got.selected), 7'(got.blank_selected), 7'(got.editing), 7'(got.commit)};
        for (int i = 0; i < 10; i++)
          if (ev[i] !== gv[i])
            $display("error: result %0d %s expected %0d got %0d",
                     checked, nm[i], ev[i], gv[i]);
      end
    end
  endfunction
endclass

module tb_clock_time_set_editor;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 160;
  localparam int NUM_PHASES      = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [1:0]  key;
  logic [6:0]  in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_date;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_year;
  logic [6:0]  out_month;
  logic [6:0]  out_date;
  logic [6:0]  out_hour;
  logic [6:0]  out_minute;
  logic [6:0]  out_second;
  logic [2:0]  selected;
  logic        blank_selected;
  logic        editing;
  logic        commit;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  time_edit_scoreboard sb = new();

  int cycle_count = 0;
  int words_sent = 0;
  int cfg_writes = 0;
  // no idling on either side while this is set
  bit steady = 0;

  always #4 clk = ~clk;

  clock_time_set_editor DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .key(key),
    .in_year(in_year),
    .in_month(in_month),
    .in_date(in_date),
    .in_hour(in_hour),
    .in_minute(in_minute),
    .in_second(in_second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_year(out_year),
    .out_month(out_month),
    .out_date(out_date),
    .out_hour(out_hour),
    .out_minute(out_minute),
    .out_second(out_second),
    .selected(selected),
    .blank_selected(blank_selected),
    .editing(editing),
    .commit(commit),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // monitor: sample both handshakes at the rising edge, results first so the
  // oldest expectation is matched before the newly accepted word is predicted
  always @(posedge clk) begin
    cte_pkg::item_t w;
    cte_pkg::res_t  r;
    cycle_count++;
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        r.year = out_year;
        r.month = out_month;
        r.date = out_date;
        r.hour = out_hour;
        r.minute = out_minute;
        r.second = out_second;
        r.selected = selected;
        r.blank_selected = blank_selected;
        r.editing = editing;
        r.commit = commit;
        sb.check(r);
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        w.cmd = cte_pkg::cmd_t'(cmd);
        w.key = cte_pkg::key_t'(key);
        w.year = in_year;
        w.month = in_month;
        w.date = in_date;
        w.hour = in_hour;
        w.minute = in_minute;
        w.second = in_second;
        sb.note(w);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, sb.pending());
      $display("clock_time_set_editor verification failed");
      $finish;
    end
  end

  // receiver side: random back-pressure, changed at the falling edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 38);
  end

  // present one word, with a random gap first, and hold it until taken
  task automatic send_word(cte_pkg::item_t w);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= w.cmd;
    key <= w.key;
    in_year <= w.year;
    in_month <= w.month;
    in_date <= w.date;
    in_hour <= w.hour;
    in_minute <= w.minute;
    in_second <= w.second;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // blink period write, only once the block has drained
  task automatic write_period(logic [15:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.set_period(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic cte_pkg::item_t mk(cte_pkg::cmd_t c, cte_pkg::key_t k,
                                        int y, int mo, int d, int h, int mi, int s);
    cte_pkg::item_t w;
    w.cmd = c;
    w.key = k;
    w.year = 7'(y);
    w.month = 4'(mo);
    w.date = 5'(d);
    w.hour = 5'(h);
    w.minute = 6'(mi);
    w.second = 6'(s);
    return w;
  endfunction

  // random word shaped by the mode: edit sessions are mostly select and
  // step keys, count mode mostly ticks, samples and entering edit mode;
  // fields a command ignores carry random noise
  function automatic cte_pkg::item_t next_random_word(bit in_edit);
    cte_pkg::item_t w;
    int    r;
    int    v;
    w.cmd = cte_pkg::cmd_t'($urandom_range(3));
    w.key = cte_pkg::key_t'($urandom_range(3));
    w.year = 7'($urandom_range(127));
    w.month = 4'($urandom_range(15));
    w.date = 5'($urandom_range(31));
    w.hour = 5'($urandom_range(31));
    w.minute = 6'($urandom_range(63));
    w.second = 6'($urandom_range(63));
    r = $urandom_range(99);
    if (in_edit) begin
      if (r < 6) begin
        w.cmd = cte_pkg::CMD_KEY;
        w.key = cte_pkg::KEY_MODE;
      end else if (r < 26) w.cmd = cte_pkg::CMD_TICK;
      else if (r < 29) w.cmd = cte_pkg::CMD_SAMPLE;
      else if (r < 31) w.cmd = cte_pkg::CMD_NOP;
      else begin
        w.cmd = cte_pkg::CMD_KEY;
        w.key = (r < 47) ? cte_pkg::KEY_NEXT
              : (r < 74) ? cte_pkg::KEY_INC : cte_pkg::KEY_DEC;
      end
    end else begin
      if (r < 18) begin
        w.cmd = cte_pkg::CMD_KEY;
        w.key = cte_pkg::KEY_MODE;
      end else if (r < 50) w.cmd = cte_pkg::CMD_TICK;
      else if (r < 82) w.cmd = cte_pkg::CMD_SAMPLE;
      else if (r < 90) begin
        w.cmd = cte_pkg::CMD_KEY;
        w.key = cte_pkg::key_t'($urandom_range(1, 3));
      end else w.cmd = cte_pkg::CMD_NOP;
    end
    if (w.cmd == cte_pkg::CMD_SAMPLE) begin
      v = $urandom_range(3);
      if (v < 2) begin
        // in-range fields, the date 1 to 31 whatever the month
        w.year = 7'($urandom_range(99));
        w.month = 4'($urandom_range(1, 12));
        w.date = 5'($urandom_range(1, 31));
        w.hour = 5'($urandom_range(23));
        w.minute = 6'($urandom_range(59));
        w.second = 6'($urandom_range(59));
      end else if (v == 3) begin
        // month ends, leap years and field limits
        w.year = 7'(4 * $urandom_range(24) + $urandom_range(1));
        case ($urandom_range(3))
          0: w.month = 4'd2;
          1: w.month = 4'd4;
          2: w.month = 4'd12;
          default: w.month = 4'd1;
        endcase
        w.date = 5'($urandom_range(27, 31));
        w.hour = $urandom_range(1) ? 5'd23 : 5'd0;
        w.minute = $urandom_range(1) ? 6'd59 : 6'd0;
        w.second = $urandom_range(1) ? 6'd59 : 6'd0;
      end
      // otherwise raw bits, out of range values included
    end
    return w;
  endfunction

  // directed opening: ignored commands, raw samples, wraps at both ends,
  // selection wrap, commit, ignored sample in edit mode, leap february
  task automatic directed_words();
    send_word(mk(cte_pkg::CMD_NOP, cte_pkg::KEY_DEC, 127, 15, 31, 31, 63, 63));
    send_word(mk(cte_pkg::CMD_TICK, cte_pkg::KEY_INC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_INC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_SAMPLE, cte_pkg::KEY_NEXT, 99, 12, 31, 23, 59, 59));
    send_word(mk(cte_pkg::CMD_SAMPLE, cte_pkg::KEY_DEC, 127, 15, 31, 31, 63, 63));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    // every field but the date out of range, one decrement pulls every one back
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_DEC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_SAMPLE, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_SAMPLE, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    // below minimum goes to maximum, above maximum to minimum
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_DEC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_INC, 0, 0, 0, 0, 0, 0));
    repeat (5) send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_NEXT, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_INC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_NEXT, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_TICK, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    // leap february, date wraps at 29
    send_word(mk(cte_pkg::CMD_SAMPLE, cte_pkg::KEY_MODE, 24, 2, 29, 12, 30, 30));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_NEXT, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_NEXT, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_INC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_DEC, 0, 0, 0, 0, 0, 0));
    send_word(mk(cte_pkg::CMD_KEY, cte_pkg::KEY_MODE, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    logic [15:0] p;
    in_valid = 1'b0;
    cmd = cte_pkg::CMD_TICK;
    key = cte_pkg::KEY_MODE;
    in_year = '0;
    in_month = '0;
    in_date = '0;
    in_hour = '0;
    in_minute = '0;
    in_second = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part runs with the blink period left at its reset value
    directed_words();

    // random phases, each with its own blink period, the extremes among them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: p = 16'd1;
        1: p = 16'd0;
        2: p = 16'd2;
        3: p = 16'hFFFF;
        4: p = 16'd3;
        5: p = cte_pkg::BLINK_TICKS_RESET;
        6: p = 16'($urandom_range(4, 40));
        default: p = 16'($urandom_range(65535));
      endcase
      write_period(p);
      // one phase runs flat out on both sides
      steady = (ph == 2);
      repeat (WORDS_PER_PHASE) send_word(next_random_word(sb.editing_now()));
      steady = 0;
    end

    // drain, then keep the clock running for any stray word
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d words across %0d blink period writes, %0d results checked",
             words_sent, cfg_writes, sb.checked);
    $display("commits seen %0d, mismatches %0d, left pending %0d",
             sb.commits, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("clock_time_set_editor verification clean");
    end else begin
      $display("clock_time_set_editor verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cte_pkg.sv
hdl/cte_in_stage.sv
hdl/cte_core.sv
hdl/clock_time_set_editor.sv
hdl/cte_checker.sv
sim/tb_clock_time_set_editor.sv
